// ----- rtl/core/gtcb_pkg.sv -----
// Shared types, constants and the score table for the top-two candidate blender.
`timescale 1ns / 1ps
package gtcb_pkg;

   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
   // The table index quotient never exceeds the depth itself.
   localparam int EXP_K_W = $clog2(EXP_TABLE_DEPTH + 1);

   localparam int D2_W = 34;
   localparam int KNUM_W = D2_W + EXP_K_W;
   localparam int BNUM_W = 37;
   localparam int DIV_NUM_W = (KNUM_W > BNUM_W) ? KNUM_W : BNUM_W;
   localparam int DIV_DEN_W = 35;
   localparam int DIV_Q_W = 17;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);
   localparam int DIV_WIDE_W = (DIV_DEN_W + DIV_Q_W > DIV_NUM_W) ?
                               (DIV_DEN_W + DIV_Q_W) : DIV_NUM_W;

   localparam logic [15:0] WEAK_LIMIT = 16'd656;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        scale;
   } entry_type;

   typedef struct packed {
      logic               is_row;
      logic               last;
      logic signed [15:0] query_x;
      logic signed [15:0] query_y;
      logic [15:0]        query_scale;
      logic [15:0]        confidence;
      logic signed [15:0] source_x;
      logic signed [15:0] source_y;
      entry_type          target;
   } item_type;

   typedef struct packed {
      entry_type   pos;
      logic [15:0] score;
   } result_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quo;
      logic               rem_nz;
   } div_rsp_type;

   typedef logic [16:0] exp_tab_type [EXP_TABLE_DEPTH];

   // Long division for the nonnegative Taylor terms, which stay below 2^32.
   function automatic longint div_small(longint num, longint den);
      longint rem;
      longint quo;
      int b;
      rem = 0;
      quo = 0;
      for (b = 31; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'd1);
         quo = quo <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Entry k is exp(-16k/depth) in Q.16, built from a Q30 Taylor series
   // times powers of exp(-1).
   function automatic exp_tab_type build_exp_table();
      exp_tab_type t;
      longint x;
      longint n;
      longint f;
      longint term;
      longint sum;
      longint v;
      int k;
      int i;
      longint j;
      for (k = 0; k < EXP_TABLE_DEPTH; k++) begin
         x = ((longint'(k) * 16) <<< 30) / EXP_TABLE_DEPTH;
         n = x >>> 30;
         f = x & 64'h3FFF_FFFF;
         term = 64'd1073741824;
         sum = 64'd1073741824;
         for (i = 1; i <= 16; i++) begin
            term = div_small((term * f) >>> 30, longint'(i));
            if ((i & 1) == 1) sum = sum - term;
            else sum = sum + term;
         end
         v = sum;
         for (j = 0; j < n; j++) v = (v * 64'd395007542) >>> 30;
         if (v < 0) v = 0;
         t[k] = 17'((v + 8192) >>> 14);
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TABLE = build_exp_table();

endpackage

// ----- rtl/core/gtcb_div.sv -----
// Shared restoring divider, one quotient bit per cycle, most significant first.
`timescale 1ns / 1ps
module gtcb_div import gtcb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIV_WIDE_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0]  den_ff;
   logic [DIV_Q_W-1:0]    quo_ff;
   logic [DIV_WIDE_W-1:0] shifted;
   logic                  fits;

   always_comb begin
      shifted = DIV_WIDE_W'(den_ff) << cnt_ff;
      fits = (rem_ff >= shifted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= DIV_WIDE_W'(req.num);
         den_ff <= req.den;
         cnt_ff <= DIV_CNT_W'(DIV_Q_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - shifted;
            quo_ff[cnt_ff] <= 1'b1;
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
   assign rsp.rem_nz = (rem_ff != '0);

endmodule

// ----- rtl/core/gtcb_front.sv -----
// Front end: accepts and classifies words into a two-entry queue.
`timescale 1ns / 1ps
module gtcb_front import gtcb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               command,
   input  logic signed [15:0] query_x,
   input  logic signed [15:0] query_y,
   input  logic [15:0]        query_scale,
   input  logic [15:0]        confidence,
   input  logic signed [15:0] source_x,
   input  logic signed [15:0] source_y,
   input  logic signed [15:0] target_x,
   input  logic signed [15:0] target_y,
   input  logic [15:0]        target_scale,
   input  logic               last,
   output logic               q_valid,
   output item_type           q_item,
   input  logic               q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_ok;
   logic       pop_ok;
   item_type   item_in;

   always_comb begin
      item_in.is_row = command;
      item_in.last = last;
      item_in.query_x = query_x;
      item_in.query_y = query_y;
      item_in.query_scale = query_scale;
      item_in.confidence = confidence;
      item_in.source_x = source_x;
      item_in.source_y = source_y;
      item_in.target.x = target_x;
      item_in.target.y = target_y;
      item_in.target.scale = target_scale;
   end

   assign full = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok = q_pop && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (pop_ok) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) slot_ff[wr_ptr_ff] <= item_in;
   end

endmodule

// ----- rtl/core/gtcb_back.sv -----
// Back end: scores rows, keeps the best two and forms the result word.
`timescale 1ns / 1ps
module gtcb_back import gtcb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic        best_only,
   output logic        res_valid,
   output result_type  res,
   input  logic        res_ready,
   output div_req_type div_req,
   input  div_rsp_type div_rsp
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_MUL    = 13'b0000000000010,
      ST_SUM    = 13'b0000000000100,
      ST_KDIV   = 13'b0000000001000,
      ST_SCORE  = 13'b0000000010000,
      ST_UPD    = 13'b0000000100000,
      ST_ECHK   = 13'b0000001000000,
      ST_FMUL   = 13'b0000010000000,
      ST_FCMP   = 13'b0000100000000,
      ST_BMUL   = 13'b0001000000000,
      ST_BSTART = 13'b0010000000000,
      ST_BDIV   = 13'b0100000000000,
      ST_OUT    = 13'b1000000000000
   } state_type;

   localparam logic [1:0] BL_X = 2'd0;
   localparam logic [1:0] BL_Y = 2'd1;
   localparam logic [1:0] BL_SCALE = 2'd2;

   state_type state_ff;

   logic signed [15:0]  held_x_ff;
   logic signed [15:0]  held_y_ff;
   logic [15:0]         held_s_ff;
   entry_type           best_ff;
   logic [15:0]         best_score_ff;
   entry_type           second_ff;
   logic [15:0]         second_score_ff;

   logic [15:0]         conf_ff;
   entry_type           tgt_ff;
   logic                last_ff;
   logic signed [16:0]  dx_ff;
   logic signed [16:0]  dy_ff;
   logic [31:0]         s2_ff;
   logic [D2_W-1:0]     dxx_ff;
   logic [D2_W-1:0]     dyy_ff;
   logic [DIV_DEN_W-1:0] kden_ff;
   logic [EXP_IDX_W-1:0] k_ff;
   logic [32:0]         prod_ff;
   result_type          res_ff;
   logic signed [16:0]  ddx_ff;
   logic signed [16:0]  ddy_ff;
   logic [31:0]         s1sq_ff;
   logic [D2_W-1:0]     fxx_ff;
   logic [D2_W-1:0]     fyy_ff;
   logic [1:0]          bsel_ff;
   logic signed [34:0]  p1_ff;
   logic signed [34:0]  p2_ff;
   logic                neg_ff;

   logic signed [16:0]  dx;
   logic signed [16:0]  dy;
   logic signed [18:0]  box;
   logic                in_box;
   logic [15:0]         score;
   logic [16:0]         bc;
   logic signed [17:0]  v1;
   logic signed [17:0]  v2;
   logic signed [35:0]  bsum;
   logic signed [37:0]  nval;
   logic [36:0]         nmag;
   logic [17:0]         qsigned;
   logic [D2_W:0]       fsum;
   logic                second_low;

   always_comb begin
      dx = 17'($signed(q_item.source_x)) - 17'(held_x_ff);
      dy = 17'($signed(q_item.source_y)) - 17'(held_y_ff);
      box = $signed({2'b00, held_s_ff, 1'b0});
      in_box = (19'(dx) <= box) && (19'(dx) >= -box) &&
               (19'(dy) <= box) && (19'(dy) >= -box);
      score = (prod_ff[32:16] > 17'd65535) ? 16'hFFFF : prod_ff[31:16];
      bc = {1'b0, best_score_ff} + {1'b0, second_score_ff};
      second_low = (second_score_ff < WEAK_LIMIT) ||
                   ({second_score_ff, 1'b0} < {1'b0, best_score_ff});
      fsum = {1'b0, fxx_ff} + {1'b0, fyy_ff};
      unique case (bsel_ff)
         BL_X: begin
            v1 = 18'(best_ff.x);
            v2 = 18'(second_ff.x);
         end
         BL_Y: begin
            v1 = 18'(best_ff.y);
            v2 = 18'(second_ff.y);
         end
         BL_SCALE: begin
            v1 = $signed({2'b00, best_ff.scale});
            v2 = $signed({2'b00, second_ff.scale});
         end
         default: begin
            v1 = '0;
            v2 = '0;
         end
      endcase
      bsum = 36'(p1_ff) + 36'(p2_ff);
      // round_div: floor((2n + d) / 2d), done on the magnitude
      nval = (38'(bsum) <<< 1) + $signed({21'd0, bc});
      nmag = nval[37] ? 37'(-nval) : 37'(nval);
      qsigned = neg_ff ? (18'd0 - ({1'b0, div_rsp.quo} + 18'(div_rsp.rem_nz)))
                       : {1'b0, div_rsp.quo};
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign res_valid = (state_ff == ST_OUT);
   assign res = res_ff;

   always_comb begin
      div_req.start = 1'b0;
      div_req.num = DIV_NUM_W'(({1'b0, dxx_ff} + {1'b0, dyy_ff}) * EXP_TABLE_DEPTH);
      div_req.den = kden_ff;
      if (state_ff == ST_SUM) begin
         div_req.start = 1'b1;
      end else if (state_ff == ST_BSTART) begin
         div_req.start = 1'b1;
         div_req.num = DIV_NUM_W'(nmag);
         div_req.den = DIV_DEN_W'({bc, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_s_ff <= '0;
         best_ff <= '0;
         best_score_ff <= '0;
         second_ff <= '0;
         second_score_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  last_ff <= q_item.last;
                  conf_ff <= q_item.confidence;
                  tgt_ff <= q_item.target;
                  dx_ff <= dx;
                  dy_ff <= dy;
                  s2_ff <= held_s_ff * held_s_ff;
                  if (!q_item.is_row) begin
                     held_x_ff <= q_item.query_x;
                     held_y_ff <= q_item.query_y;
                     held_s_ff <= q_item.query_scale;
                     best_ff <= '0;
                     best_score_ff <= '0;
                     second_ff <= '0;
                     second_score_ff <= '0;
                     state_ff <= q_item.last ? ST_ECHK : ST_IDLE;
                  end else if ((held_s_ff != '0) && in_box) begin
                     state_ff <= ST_MUL;
                  end else begin
                     state_ff <= q_item.last ? ST_ECHK : ST_IDLE;
                  end
               end
            end
            ST_MUL: begin
               dxx_ff <= D2_W'(dx_ff * dx_ff);
               dyy_ff <= D2_W'(dy_ff * dy_ff);
               kden_ff <= {s2_ff, 3'b000};
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_KDIV;
            end
            ST_KDIV: begin
               if (div_rsp.done) begin
                  k_ff <= (div_rsp.quo >= DIV_Q_W'(EXP_TABLE_DEPTH - 1)) ?
                          EXP_IDX_W'(EXP_TABLE_DEPTH - 1) : div_rsp.quo[EXP_IDX_W-1:0];
                  state_ff <= ST_SCORE;
               end
            end
            ST_SCORE: begin
               prod_ff <= 33'(conf_ff) * 33'(EXP_TABLE[k_ff]);
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               // A tie with the best replaces it and pushes it to second place.
               if (score >= best_score_ff) begin
                  second_ff <= best_ff;
                  second_score_ff <= best_score_ff;
                  best_ff <= tgt_ff;
                  best_score_ff <= score;
               end else if (score > second_score_ff) begin
                  second_ff <= tgt_ff;
                  second_score_ff <= score;
               end
               state_ff <= last_ff ? ST_ECHK : ST_IDLE;
            end
            ST_ECHK: begin
               ddx_ff <= 17'(best_ff.x) - 17'(second_ff.x);
               ddy_ff <= 17'(best_ff.y) - 17'(second_ff.y);
               s1sq_ff <= best_ff.scale * best_ff.scale;
               if (best_score_ff == '0) begin
                  res_ff <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  res_ff.pos <= best_ff;
                  if (best_only) begin
                     res_ff.score <= best_score_ff;
                     state_ff <= ST_OUT;
                  end else begin
                     res_ff.score <= best_score_ff >> 1;
                     state_ff <= second_low ? ST_OUT : ST_FMUL;
                  end
               end
            end
            ST_FMUL: begin
               fxx_ff <= D2_W'(ddx_ff * ddx_ff);
               fyy_ff <= D2_W'(ddy_ff * ddy_ff);
               state_ff <= ST_FCMP;
            end
            ST_FCMP: begin
               bsel_ff <= BL_X;
               state_ff <= ({fsum, 2'b00} > (D2_W + 3)'(s1sq_ff)) ? ST_OUT : ST_BMUL;
            end
            ST_BMUL: begin
               p1_ff <= 35'($signed({1'b0, best_score_ff})) * 35'(v1);
               p2_ff <= 35'($signed({1'b0, second_score_ff})) * 35'(v2);
               state_ff <= ST_BSTART;
            end
            ST_BSTART: begin
               neg_ff <= nval[37];
               state_ff <= ST_BDIV;
            end
            ST_BDIV: begin
               if (div_rsp.done) begin
                  unique case (bsel_ff)
                     BL_X: res_ff.pos.x <= qsigned[15:0];
                     BL_Y: res_ff.pos.y <= qsigned[15:0];
                     default: res_ff.pos.scale <= qsigned[15:0];
                  endcase
                  if (bsel_ff == BL_SCALE) begin
                     res_ff.score <= bc[16:1];
                     state_ff <= ST_OUT;
                  end else begin
                     bsel_ff <= bsel_ff + 2'd1;
                     state_ff <= ST_BMUL;
                  end
               end
            end
            ST_OUT: begin
               if (res_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/core/gaussian_top2_candidate_blend.sv -----
// Top level of the top-two candidate blender with its result register.
`timescale 1ns / 1ps
// Usage: words enter through push/full. A start word (command 0) latches the
// query point and scale and clears the held candidates; row words (command 1)
// are scored against the held query and ranked. A word with last set yields
// one result word, read through empty/pop; the result waits in an output
// register while the back end goes on taking words from the front queue.
// The back end takes a start word or a rejected candidate row in its idle
// state alone. A scored row waits on the 17-step shared divider that forms
// the score table index. Emission goes out directly, after a distance check
// for a far second, or after a blend, which runs three divisions through
// the same divider. Reset clears the queue, the result register, the held
// query, the held candidates and the best-only mode. When the receiver does
// not pop, the back end holds its next result, and push sees full once the
// queue has filled. The user writes the best-only mode through
// csr_wr_en/csr_wr_data while idle; the block does not enforce it.
module gaussian_top2_candidate_blend import gtcb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_command,
   input  logic signed [15:0] req_query_x,
   input  logic signed [15:0] req_query_y,
   input  logic [15:0]        req_query_scale,
   input  logic [15:0]        req_confidence,
   input  logic signed [15:0] req_source_x,
   input  logic signed [15:0] req_source_y,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic [15:0]        req_target_scale,
   input  logic               req_last,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic [15:0]        rsp_out_scale,
   output logic [15:0]        rsp_out_score,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   logic        best_only_ff;
   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   logic        res_valid;
   result_type  res;
   logic        res_ready;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        out_valid_ff;
   result_type  out_ff;

   gtcb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .command      (req_command),
      .query_x      (req_query_x),
      .query_y      (req_query_y),
      .query_scale  (req_query_scale),
      .confidence   (req_confidence),
      .source_x     (req_source_x),
      .source_y     (req_source_y),
      .target_x     (req_target_x),
      .target_y     (req_target_y),
      .target_scale (req_target_scale),
      .last         (req_last),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   gtcb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gtcb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .best_only (best_only_ff),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   assign res_ready = !out_valid_ff;
   assign empty = !out_valid_ff;
   assign rsp_out_x = out_ff.pos.x;
   assign rsp_out_y = out_ff.pos.y;
   assign rsp_out_scale = out_ff.pos.scale;
   assign rsp_out_score = out_ff.score;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_only_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) best_only_ff <= csr_wr_data;
         if (res_valid && res_ready) begin
            out_valid_ff <= 1'b1;
         end else if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) out_ff <= res;
   end

endmodule
